### design/clx_pkg.sv
// Shared types, character constants and character-class helpers for the
// C-like token lexer. No dependencies; imported by every design file.
package clx_pkg;

    // Fixed widths of the result fields
    localparam int unsigned LINE_NUM_W   = 16;
    localparam int unsigned COLUMN_NUM_W = 16;
    localparam int unsigned DEF_LINE_BITS   = 16;
    localparam int unsigned DEF_COLUMN_BITS = 16;

    // Depth of the record queue between scanner and output side
    localparam int unsigned QUEUE_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [1:0] {
        KIND_VAL = 2'd0,
        KIND_END = 2'd1,
        KIND_ERR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        TT_PRE     = 3'd0,
        TT_COMMENT = 3'd1,
        TT_QUOTE   = 3'd2,
        TT_NUM     = 3'd3,
        TT_ID      = 3'd4,
        TT_CHAR    = 3'd5
    } t_ttype;

    // One result without position
    typedef struct packed {
        t_kind      kind;
        t_ttype     ttype;
        logic [7:0] value;
    } t_res;

    // All results caused by one input byte
    typedef struct packed {
        logic                    two;
        t_res                    r0;
        t_res                    r1;
        logic [LINE_NUM_W-1:0]   line;
        logic [COLUMN_NUM_W-1:0] col;
    } t_rec;

    function automatic logic is_nl(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_idchar(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

### design/clx_front.sv
// Scanner front end: classifies each accepted byte, keeps the scan mode and
// line/column counters, and emits one record of up to two results. Uses clx_pkg.
module clx_front
    import clx_pkg::*;
#(
    parameter int unsigned LINE_BITS   = DEF_LINE_BITS,
    parameter int unsigned COLUMN_BITS = DEF_COLUMN_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_text,
    output logic       o_rec_valid,
    output t_rec       o_rec
);

    typedef enum logic [7:0] {
        M_IDLE  = 8'b0000_0001,
        M_PRE   = 8'b0000_0010,
        M_SLASH = 8'b0000_0100,
        M_LINE  = 8'b0000_1000,
        M_BLOCK = 8'b0001_0000,
        M_QUOTE = 8'b0010_0000,
        M_NUM   = 8'b0100_0000,
        M_ID    = 8'b1000_0000
    } t_mode;

    typedef enum logic [1:0] {
        NL_NONE = 2'd0,
        NL_CR   = 2'd1,
        NL_LF   = 2'd2
    } t_nl;

    typedef struct packed {
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_pair;

    typedef struct packed {
        t_mode mode;
        logic  emit;
        t_res  res;
    } t_start;

    function automatic t_res mk(input t_kind k, input t_ttype t, input logic [7:0] v);
        t_res r;
        r.kind  = k;
        r.ttype = t;
        r.value = v;
        return r;
    endfunction

    function automatic t_pair add(input t_pair p, input t_res r);
        t_pair q;
        q = p;
        if (p.n == 2'd0) begin
            q.r0 = r;
        end else if (p.n == 2'd1) begin
            q.r1 = r;
        end
        if (p.n != 2'd2) begin
            q.n = p.n + 2'd1;
        end
        return q;
    endfunction

    // First byte of a new token
    function automatic t_start start_tok(input logic [7:0] c);
        t_start s;
        s.mode = M_IDLE;
        s.emit = 1'b0;
        s.res  = mk(KIND_VAL, TT_PRE, c);
        priority if (c == CH_HASH) begin
            s.mode = M_PRE;
            s.emit = 1'b1;
        end else if (c == CH_SLASH) begin
            s.mode = M_SLASH;
        end else if (is_nl(c)) begin
            s.mode = M_IDLE;
        end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
            s.mode = M_QUOTE;
        end else if (is_digit(c)) begin
            s.mode = M_NUM;
            s.emit = 1'b1;
            s.res  = mk(KIND_VAL, TT_NUM, c);
        end else if (is_alpha(c) || (c == CH_UNDER)) begin
            s.mode = M_ID;
            s.emit = 1'b1;
            s.res  = mk(KIND_VAL, TT_ID, c);
        end else if (is_space(c)) begin
            s.mode = M_IDLE;
        end else begin
            s.emit = 1'b1;
            s.res  = mk(KIND_END, TT_CHAR, c);
        end
        return s;
    endfunction

    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    t_mode                  r_mode, n_mode;
    logic [7:0]             r_quote, n_quote;
    logic                   r_esc, n_esc;
    logic                   r_star, n_star;
    t_nl                    r_nl, n_nl;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COLUMN_BITS-1:0] r_col, n_col;

    t_pair  w_pair;

    logic [LINE_BITS+LINE_NUM_W-1:0]     w_line_ext;
    logic [COLUMN_BITS+COLUMN_NUM_W-1:0] w_col_ext;

    // Per-mode scan of the byte, then end-of-text wrap-up
    always_comb begin
        t_pair  p;
        t_pair  f;
        t_start st;
        logic   started;
        logic [7:0] c;
        t_nl    me;

        c       = i_data_byte;
        p       = '0;
        f       = '0;
        started = 1'b0;
        st      = start_tok(c);
        n_mode  = r_mode;
        n_quote = r_quote;
        n_esc   = r_esc;
        n_star  = r_star;

        unique case (r_mode)
            M_PRE: begin
                if (is_nl(c)) begin
                    p = add(p, mk(KIND_END, TT_PRE, 8'h00));
                    n_mode = M_IDLE;
                end else begin
                    p = add(p, mk(KIND_VAL, TT_PRE, c));
                end
            end
            M_SLASH: begin
                priority if (c == CH_SLASH) begin
                    n_mode = M_LINE;
                end else if (c == CH_STAR) begin
                    n_mode = M_BLOCK;
                    n_star = 1'b0;
                end else begin
                    p = add(p, mk(KIND_END, TT_CHAR, CH_SLASH));
                    n_mode = st.mode;
                    if (st.emit) begin
                        p = add(p, st.res);
                    end
                    started = st.emit && (st.res.kind == KIND_VAL);
                end
            end
            M_LINE: begin
                if (is_nl(c)) begin
                    p = add(p, mk(KIND_END, TT_COMMENT, 8'h00));
                    n_mode = M_IDLE;
                end else begin
                    p = add(p, mk(KIND_VAL, TT_COMMENT, c));
                end
            end
            M_BLOCK: begin
                // a star is held back until the next byte shows whether it closes
                priority if (r_star) begin
                    if (c == CH_SLASH) begin
                        p = add(p, mk(KIND_END, TT_COMMENT, 8'h00));
                        n_mode = M_IDLE;
                        n_star = 1'b0;
                    end else begin
                        p = add(p, mk(KIND_VAL, TT_COMMENT, CH_STAR));
                        if (c != CH_STAR) begin
                            n_star = 1'b0;
                            p = add(p, mk(KIND_VAL, TT_COMMENT, c));
                        end
                    end
                end else if (c == CH_STAR) begin
                    n_star = 1'b1;
                end else begin
                    p = add(p, mk(KIND_VAL, TT_COMMENT, c));
                end
            end
            M_QUOTE: begin
                priority if (r_esc) begin
                    p = add(p, mk(KIND_VAL, TT_QUOTE, c));
                    n_esc = 1'b0;
                end else if (c == CH_BSLASH) begin
                    p = add(p, mk(KIND_VAL, TT_QUOTE, c));
                    n_esc = 1'b1;
                end else if (c == r_quote) begin
                    p = add(p, mk(KIND_END, TT_QUOTE, 8'h00));
                    n_mode = M_IDLE;
                end else begin
                    p = add(p, mk(KIND_VAL, TT_QUOTE, c));
                end
            end
            M_NUM, M_ID: begin
                if ((r_mode == M_NUM) ? is_digit(c) : is_idchar(c)) begin
                    p = add(p, mk(KIND_VAL, (r_mode == M_NUM) ? TT_NUM : TT_ID, c));
                end else begin
                    p = add(p, mk(KIND_END, (r_mode == M_NUM) ? TT_NUM : TT_ID, 8'h00));
                    n_mode = st.mode;
                    if (st.emit) begin
                        p = add(p, st.res);
                    end
                    started = st.emit && (st.res.kind == KIND_VAL);
                end
            end
            default: begin
                n_mode = st.mode;
                if (st.emit) begin
                    p = add(p, st.res);
                end
                started = st.emit && (st.res.kind == KIND_VAL);
            end
        endcase

        // a quote that opens a literal is remembered as its terminator
        if ((n_mode == M_QUOTE) && (r_mode != M_QUOTE)) begin
            n_quote = c;
            n_esc   = 1'b0;
        end

        // newline merge and position counters
        me = (c == CH_CR) ? NL_CR : NL_LF;
        if (is_nl(c)) begin
            if ((r_nl != NL_NONE) && (r_nl != me)) begin
                n_nl   = NL_NONE;
                n_line = r_line;
            end else begin
                n_nl   = me;
                n_line = (r_line != LINE_MAX) ? r_line + LINE_ONE : r_line;
            end
            n_col = COL_ONE;
        end else begin
            n_nl   = NL_NONE;
            n_line = r_line;
            n_col  = (r_col != COL_MAX) ? r_col + COL_ONE : r_col;
        end

        // end of text: close open tokens, flag unterminated ones, reset state
        if (i_end_of_text) begin
            unique case (n_mode)
                M_PRE, M_NUM, M_ID, M_LINE: begin
                    if (started) begin
                        if (p.n == 2'd2) begin
                            p.r1.kind = KIND_END;
                        end else begin
                            p.r0.kind = KIND_END;
                        end
                    end else begin
                        p = add(p, mk(KIND_END,
                            (n_mode == M_PRE) ? TT_PRE :
                            (n_mode == M_NUM) ? TT_NUM :
                            (n_mode == M_ID)  ? TT_ID : TT_COMMENT, 8'h00));
                    end
                end
                M_BLOCK, M_QUOTE, M_SLASH: begin
                    if ((p.n != 2'd0) && (p.r0.kind != KIND_VAL)) begin
                        f = add(f, p.r0);
                    end
                    if ((p.n == 2'd2) && (p.r1.kind != KIND_VAL)) begin
                        f = add(f, p.r1);
                    end
                    p = add(f, mk(KIND_ERR,
                        (n_mode == M_QUOTE) ? TT_QUOTE : TT_COMMENT, 8'h00));
                end
                default: begin
                end
            endcase
            n_mode  = M_IDLE;
            n_quote = 8'h00;
            n_esc   = 1'b0;
            n_star  = 1'b0;
            n_nl    = NL_NONE;
            n_line  = LINE_ONE;
            n_col   = COL_ONE;
        end

        w_pair = p;
    end

    // Scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_quote <= 8'h00;
            r_esc   <= 1'b0;
            r_star  <= 1'b0;
            r_nl    <= NL_NONE;
            r_line  <= LINE_ONE;
            r_col   <= COL_ONE;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_quote <= n_quote;
            r_esc   <= n_esc;
            r_star  <= n_star;
            r_nl    <= n_nl;
            r_line  <= n_line;
            r_col   <= n_col;
        end
    end

    // Position reported is that of the byte itself, cut or padded to 16 bits
    assign w_line_ext = {{LINE_NUM_W{1'b0}}, r_line};
    assign w_col_ext  = {{COLUMN_NUM_W{1'b0}}, r_col};

    assign o_rec_valid = i_accept && (w_pair.n != 2'd0);
    assign o_rec.two   = (w_pair.n == 2'd2);
    assign o_rec.r0    = w_pair.r0;
    assign o_rec.r1    = w_pair.r1;
    assign o_rec.line  = w_line_ext[LINE_NUM_W-1:0];
    assign o_rec.col   = w_col_ext[COLUMN_NUM_W-1:0];

endmodule

### design/clx_queue.sv
// Short record queue between the scanner and the output side, so that each
// side stalls on its own. Register storage; uses clx_pkg.
module clx_queue
    import clx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output t_rec o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_rec             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

### design/clx_back.sv
// Output side: hands out the one or two results of the head record one at a
// time and retires the record after its last one. Uses clx_pkg.
module clx_back
    import clx_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_rec                    i_head,
    input  logic                    i_head_empty,
    input  logic                    i_pop,
    output logic                    o_rec_done,
    output logic [1:0]              o_kind,
    output logic [2:0]              o_token_type,
    output logic [7:0]              o_value_byte,
    output logic [LINE_NUM_W-1:0]   o_line_number,
    output logic [COLUMN_NUM_W-1:0] o_column_number,
    output logic                    o_last_of_run
);

    logic r_idx;
    t_res w_cur;

    assign w_cur           = r_idx ? i_head.r1 : i_head.r0;
    assign o_last_of_run   = (r_idx == i_head.two);
    assign o_rec_done      = i_pop && !i_head_empty && o_last_of_run;
    assign o_kind          = w_cur.kind;
    assign o_token_type    = w_cur.ttype;
    assign o_value_byte    = w_cur.value;
    assign o_line_number   = i_head.line;
    assign o_column_number = i_head.col;

    // Index of the result being offered within the head record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 1'b0;
        end else if (i_pop && !i_head_empty) begin
            r_idx <= !o_last_of_run;
        end
    end

endmodule

### design/c_like_token_lexer.sv
// C-like token lexer, top level: scanner front end, record queue and output
// side. Depends on clx_pkg, clx_front, clx_queue and clx_back.
//
// Usage: source bytes enter through a queue-style port: an item is taken at
// each clock edge with push high and full low; i_end_of_text marks the final
// byte of a text. Results leave through a queue-style port: while empty is
// low the oldest result sits on the o_ ports and pop takes it.
// Each byte gives zero, one or two results (value byte, token end or lexical
// error), all tagged with that byte's line and column; o_last_of_run marks
// the last result of a byte.
// A byte's results, if any, are written into the record queue when it is taken.
// Throughput: one byte per cycle while full is low; a byte with two results holds the output
// port for two pops, so the sustained rate is set by the single output port.
// A four-record queue sits between scanner and output side: when pop stays
// low, bytes are still taken until the queue is full, then full rises.
// Reset (synchronous, i_rst_n low) empties the queue and sets the scanner to
// idle at line 1, column 1; the scanner returns there after every final byte.
module c_like_token_lexer
    import clx_pkg::*;
#(
    parameter int unsigned LINE_BITS   = DEF_LINE_BITS,
    parameter int unsigned COLUMN_BITS = DEF_COLUMN_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_end_of_text,
    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              o_kind,
    output logic [2:0]              o_token_type,
    output logic [7:0]              o_value_byte,
    output logic [LINE_NUM_W-1:0]   o_line_number,
    output logic [COLUMN_NUM_W-1:0] o_column_number,
    output logic                    o_last_of_run
);

    logic w_accept;
    logic w_rec_valid;
    t_rec w_rec;
    t_rec w_head;
    logic w_full;
    logic w_empty;
    logic w_rec_done;

    assign w_accept = push && !w_full;
    assign full     = w_full;
    assign empty    = w_empty;

    clx_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_rec_valid   (w_rec_valid),
        .o_rec         (w_rec)
    );

    clx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_valid),
        .i_rec   (w_rec),
        .i_pop   (w_rec_done),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    clx_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_head_empty    (w_empty),
        .i_pop           (pop),
        .o_rec_done      (w_rec_done),
        .o_kind          (o_kind),
        .o_token_type    (o_token_type),
        .o_value_byte    (o_value_byte),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last_of_run   (o_last_of_run)
    );

    // The scanner never offers a record the queue cannot take
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rec_valid |-> !w_full)
        else $error("record pushed into full queue");

    // Taking the first of two results leaves the second on the port
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_of_run) |=> (!empty && o_last_of_run))
        else $error("second result of a byte lost");

    // A lexical error is always the last result of its byte
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == KIND_ERR)) |-> o_last_of_run)
        else $error("error result followed by another result");

endmodule
